>>> src/idxlst_pkg.sv
// Package for the indexed list block: request and response types, codes,
// sizes and the microcode ROM of the list sequencer.
// Depends on nothing; used by indexed_list_insert_erase.
package idxlst_pkg;

  // Storage size and derived widths
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Request modes
  typedef enum logic [2:0] {
    MD_PUSH_BACK  = 3'd0,
    MD_PUSH_FRONT = 3'd1,
    MD_INSERT     = 3'd2,
    MD_UPDATE     = 3'd3,
    MD_ERASE      = 3'd4,
    MD_POP_BACK   = 3'd5,
    MD_POP_FRONT  = 3'd6,
    MD_GET        = 3'd7
  } mode_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Payload of one request item
  typedef struct packed {
    logic        [2:0]  mode;
    logic        [5:0]  position;
    logic signed [31:0] item_value;
  } request_t;

  // Payload of one response item
  typedef struct packed {
    logic signed [31:0] read_value;
    logic        [6:0]  entry_count;
    logic        [1:0]  status;
  } response_t;

  // Microcode addresses
  typedef enum logic [3:0] {
    U_INS_LOOP = 4'd0,
    U_INS_WR   = 4'd1,
    U_ERA_LOOP = 4'd2,
    U_ERA_END  = 4'd3,
    U_UPD      = 4'd4,
    U_GET_RD   = 4'd5,
    U_GET_OUT  = 4'd6,
    U_POP_BACK = 4'd7,
    U_FAIL     = 4'd8
  } uaddr_t;

  // Branch conditions: taken goes to target, else to the next step
  typedef enum logic [1:0] {
    C_NONE     = 2'd0,
    C_INS_MORE = 2'd1,  // pointer still above the insert position
    C_ERA_MORE = 2'd2   // pointer plus one still below the count
  } cond_t;

  // Word moves, done only while the branch is taken
  typedef enum logic [1:0] {
    MV_NONE = 2'd0,
    MV_DOWN = 2'd1,  // copy entry ptr-1 to ptr, pointer steps down
    MV_UP   = 2'd2   // copy entry ptr+1 to ptr, pointer steps up
  } move_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  // One control word
  typedef struct packed {
    cond_t   cond;
    uaddr_t  target;
    move_t   mv;
    logic    wr_word;   // write request word at the position
    logic    rd_pos;    // read entry at the position
    cnt_op_t cnt_op;
    logic    capture;   // return the read data
    logic    last;      // final step, response goes out
  } uctrl_t;

  // Microcode ROM
  function automatic uctrl_t ucode(input uaddr_t a);
    uctrl_t w;
    w = '0;
    case (a)
      U_INS_LOOP: begin
        w.cond   = C_INS_MORE;
        w.target = U_INS_LOOP;
        w.mv     = MV_DOWN;
      end
      U_INS_WR: begin
        w.wr_word = 1'b1;
        w.cnt_op  = CNT_INC;
        w.last    = 1'b1;
      end
      U_ERA_LOOP: begin
        w.cond   = C_ERA_MORE;
        w.target = U_ERA_LOOP;
        w.mv     = MV_UP;
      end
      U_ERA_END: begin
        w.cnt_op = CNT_DEC;
        w.last   = 1'b1;
      end
      U_UPD: begin
        w.wr_word = 1'b1;
        w.last    = 1'b1;
      end
      U_GET_RD: begin
        w.rd_pos = 1'b1;
      end
      U_GET_OUT: begin
        w.capture = 1'b1;
        w.last    = 1'b1;
      end
      U_POP_BACK: begin
        w.cnt_op = CNT_DEC;
        w.last   = 1'b1;
      end
      U_FAIL: begin
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> src/indexed_list_insert_erase.sv
// Indexed list (fixed-capacity array list) top level: microcode sequencer, a one-write
// one-read entry memory and the response register. Depends on idxlst_pkg.
// Throughput: one item at a time; the next is taken at the edge ending done.
// Synchronous reset empties the list and idles the sequencer; the receiver cannot stall.
module indexed_list_insert_erase (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  idxlst_pkg::request_t  request,
  output logic                  done,
  output idxlst_pkg::response_t response
);

  localparam int AW = idxlst_pkg::ADDR_W;
  localparam int CW = idxlst_pkg::CNT_W;
  localparam int DW = idxlst_pkg::DATA_WIDTH;

  // Entry memory
  logic [DW-1:0] mem [idxlst_pkg::DEPTH];

  // Sequencer and datapath registers
  idxlst_pkg::uaddr_t  pc;
  idxlst_pkg::status_t st;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       ptr;
  logic [CW-1:0]       pos;
  logic [DW-1:0]       word;
  logic [DW-1:0]       rdata;
  logic                pend;
  logic [AW-1:0]       pend_addr;

  idxlst_pkg::uctrl_t  uc;
  logic                accept;
  logic                taken;
  logic                mv_en;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [DW-1:0]       wr_data;
  logic [CW-1:0]       cnt_next;
  idxlst_pkg::uaddr_t  pc_next;

  // Dispatch values worked out on accept
  idxlst_pkg::mode_t   md;
  idxlst_pkg::status_t ent_st;
  idxlst_pkg::uaddr_t  ent_pc;
  logic [CW-1:0]       ent_pos;
  logic [CW-1:0]       ent_ptr;
  logic [CW-1:0]       req_pos;

  assign accept  = start & ~busy;
  assign md      = idxlst_pkg::mode_t'(request.mode);
  assign req_pos = CW'(request.position);

  // Request checks and microcode entry point
  always_comb begin
    ent_st  = idxlst_pkg::ST_OK;
    ent_pc  = idxlst_pkg::U_FAIL;
    ent_pos = req_pos;
    ent_ptr = req_pos;
    case (md)
      idxlst_pkg::MD_PUSH_BACK, idxlst_pkg::MD_PUSH_FRONT, idxlst_pkg::MD_INSERT: begin
        if (md == idxlst_pkg::MD_PUSH_BACK) begin
          ent_pos = cnt;
        end else if (md == idxlst_pkg::MD_PUSH_FRONT) begin
          ent_pos = '0;
        end
        ent_ptr = cnt;
        if (ent_pos > cnt) begin
          ent_st = idxlst_pkg::ST_RANGE;
        end else if (cnt >= CW'(idxlst_pkg::DEPTH)) begin
          ent_st = idxlst_pkg::ST_FULL;
        end else begin
          ent_pc = idxlst_pkg::U_INS_LOOP;
        end
      end
      idxlst_pkg::MD_UPDATE, idxlst_pkg::MD_ERASE, idxlst_pkg::MD_GET: begin
        if (cnt == '0) begin
          ent_st = idxlst_pkg::ST_EMPTY;
        end else if (req_pos >= cnt) begin
          ent_st = idxlst_pkg::ST_RANGE;
        end else if (md == idxlst_pkg::MD_UPDATE) begin
          ent_pc = idxlst_pkg::U_UPD;
        end else if (md == idxlst_pkg::MD_ERASE) begin
          ent_pc = idxlst_pkg::U_ERA_LOOP;
        end else begin
          ent_pc = idxlst_pkg::U_GET_RD;
        end
      end
      idxlst_pkg::MD_POP_BACK: begin
        if (cnt == '0) begin
          ent_st = idxlst_pkg::ST_EMPTY;
        end else begin
          ent_pc = idxlst_pkg::U_POP_BACK;
        end
      end
      default: begin
        // pop front: erase at the head
        ent_pos = '0;
        ent_ptr = '0;
        if (cnt == '0) begin
          ent_st = idxlst_pkg::ST_EMPTY;
        end else begin
          ent_pc = idxlst_pkg::U_ERA_LOOP;
        end
      end
    endcase
  end

  // Control word decode, branch and next step
  always_comb begin
    uc = idxlst_pkg::ucode(pc);
    case (uc.cond)
      idxlst_pkg::C_INS_MORE: taken = (ptr != pos);
      idxlst_pkg::C_ERA_MORE: taken = ((ptr + CW'(1)) < cnt);
      default:                taken = 1'b0;
    endcase
    mv_en   = busy && (uc.mv != idxlst_pkg::MV_NONE) && taken;
    pc_next = taken ? uc.target : idxlst_pkg::uaddr_t'(pc + 4'd1);
  end

  // Memory port selection
  always_comb begin
    rd_en   = mv_en || (busy && uc.rd_pos);
    rd_addr = pos[AW-1:0];
    if (uc.mv == idxlst_pkg::MV_DOWN) begin
      rd_addr = AW'(ptr - CW'(1));
    end else if (uc.mv == idxlst_pkg::MV_UP) begin
      rd_addr = AW'(ptr + CW'(1));
    end
    // a pending move write never meets a word write in the same step
    wr_en   = pend || (busy && uc.wr_word);
    wr_addr = pend ? pend_addr : pos[AW-1:0];
    wr_data = pend ? rdata : word;
  end

  // Count update
  always_comb begin
    cnt_next = cnt;
    if (busy) begin
      case (uc.cnt_op)
        idxlst_pkg::CNT_INC: cnt_next = cnt + CW'(1);
        idxlst_pkg::CNT_DEC: cnt_next = cnt - CW'(1);
        default:             cnt_next = cnt;
      endcase
    end
  end

  // Entry memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      pend <= 1'b0;
      pc   <= idxlst_pkg::U_FAIL;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      pend <= mv_en;
      done <= busy && uc.last;
      if (accept) begin
        busy <= 1'b1;
        pc   <= ent_pc;
      end else if (busy) begin
        if (uc.last) begin
          busy <= 1'b0;
        end
        pc <= pc_next;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pos  <= ent_pos;
      ptr  <= ent_ptr;
      word <= DW'(request.item_value);
      st   <= ent_st;
    end else if (mv_en) begin
      pend_addr <= ptr[AW-1:0];
      if (uc.mv == idxlst_pkg::MV_DOWN) begin
        ptr <= ptr - CW'(1);
      end else begin
        ptr <= ptr + CW'(1);
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (busy && uc.last) begin
      response.read_value  <= uc.capture ? 32'(rdata) : '0;
      response.entry_count <= 7'(cnt_next);
      response.status      <= st;
    end
  end

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("response while still busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(idxlst_pkg::DEPTH))
    else $error("entry count above capacity");
  a_no_clash: assert property (@(posedge clk) disable iff (rst)
    !(pend && busy && uc.wr_word))
    else $error("move write and word write in the same cycle");

endmodule

>>> dv/list_checker.sv
`timescale 1ns / 1ps
// Response checker for indexed_list_insert_erase: predicts each response from the
// accepted requests and compares it field by field. Depends on idxlst_pkg.
module list_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  idxlst_pkg::request_t  request,
  input  logic                  done,
  input  idxlst_pkg::response_t response,
  output int                    faults,
  output int unsigned           outstanding
);

  // Predicted list contents and length
  logic signed [31:0]    held [idxlst_pkg::DEPTH];
  int unsigned           held_n;

  // Responses owed by the block, oldest first
  idxlst_pkg::response_t awaited [$];
  int                    fault_n  = 0;
  int unsigned           answered = 0;

  assign faults = fault_n;

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    if (fault_n < 100)
      $display("%0t ns  response %0d %s: got %0h, expected %0h",
               $time, answered, what, got, want);
    fault_n++;
  endtask

  // Shift entries above 'at' down one place
  function automatic void close_gap(input int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < held_n; i++) held[i] = held[i + 1];
  endfunction

  // Apply one request to the predicted list; returns the response it earns
  function automatic idxlst_pkg::response_t list_apply(input idxlst_pkg::request_t rq);
    idxlst_pkg::response_t r;
    int unsigned           at;
    int unsigned           i;
    r.read_value = '0;
    r.status     = idxlst_pkg::ST_OK;
    at           = rq.position;
    case (idxlst_pkg::mode_t'(rq.mode))
      idxlst_pkg::MD_PUSH_BACK, idxlst_pkg::MD_PUSH_FRONT, idxlst_pkg::MD_INSERT: begin
        if (rq.mode == idxlst_pkg::MD_PUSH_BACK) at = held_n;
        else if (rq.mode == idxlst_pkg::MD_PUSH_FRONT) at = 0;
        // range is judged before fullness
        if (at > held_n) r.status = idxlst_pkg::ST_RANGE;
        else if (held_n >= idxlst_pkg::DEPTH) r.status = idxlst_pkg::ST_FULL;
        else begin
          for (i = held_n; i > at; i--) held[i] = held[i - 1];
          held[at] = rq.item_value;
          held_n++;
        end
      end
      idxlst_pkg::MD_UPDATE, idxlst_pkg::MD_ERASE, idxlst_pkg::MD_GET: begin
        if (held_n == 0) r.status = idxlst_pkg::ST_EMPTY;
        else if (at >= held_n) r.status = idxlst_pkg::ST_RANGE;
        else if (rq.mode == idxlst_pkg::MD_UPDATE) held[at] = rq.item_value;
        else if (rq.mode == idxlst_pkg::MD_ERASE) begin
          close_gap(at);
          held_n--;
        end else r.read_value = held[at];
      end
      idxlst_pkg::MD_POP_BACK: begin
        if (held_n == 0) r.status = idxlst_pkg::ST_EMPTY;
        else held_n--;
      end
      default: begin
        if (held_n == 0) r.status = idxlst_pkg::ST_EMPTY;
        else begin
          close_gap(0);
          held_n--;
        end
      end
    endcase
    r.entry_count = 7'(held_n);
    return r;
  endfunction

  // Compare responses first, then log the item accepted at this edge
  always @(posedge clk) begin
    idxlst_pkg::response_t want;
    if (rst) begin
      held_n = 0;
      awaited.delete();
      outstanding <= 0;
    end else begin
      if (done) begin
        if (awaited.size() == 0) begin
          log_mismatch("with no request waiting, entry_count",
                       32'(response.entry_count), '0);
        end else begin
          want = awaited[0];
          awaited.delete(0);
          if (response.read_value !== want.read_value)
            log_mismatch("read_value", response.read_value, want.read_value);
          if (response.entry_count !== want.entry_count)
            log_mismatch("entry_count", 32'(response.entry_count),
                         32'(want.entry_count));
          if (response.status !== want.status)
            log_mismatch("status", 32'(response.status), 32'(want.status));
        end
        answered++;
      end
      if (start && !busy) awaited.insert(awaited.size(), list_apply(request));
      outstanding <= awaited.size();
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for indexed_list_insert_erase: clock, reset, request stimulus and
// the verdict. Depends on idxlst_pkg, the block and list_checker.
module tb_top;

  typedef enum int {PH_GROW, PH_BRIM, PH_CHURN, PH_SHRINK} phase_t;

  logic                  clk   = 1'b0;
  logic                  rst   = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  done;
  idxlst_pkg::request_t  request = '0;
  idxlst_pkg::response_t response;
  int                    faults;
  int unsigned           outstanding;

  // Rough length of the list, kept only to aim positions and count coverage
  int occ          = 0;
  int peak         = 0;
  int full_refused = 0;
  int sent         = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_list_insert_erase u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
  );

  list_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .response    (response),
    .faults      (faults),
    .outstanding (outstanding)
  );

  // Length bookkeeping for an accepted item
  function automatic void note_accepted(input idxlst_pkg::mode_t m, input int p);
    case (m)
      idxlst_pkg::MD_PUSH_BACK, idxlst_pkg::MD_PUSH_FRONT, idxlst_pkg::MD_INSERT: begin
        if (m != idxlst_pkg::MD_INSERT || p <= occ) begin
          if (occ < idxlst_pkg::DEPTH) occ++;
          else full_refused++;
        end
      end
      idxlst_pkg::MD_ERASE:                              if (p < occ) occ--;
      idxlst_pkg::MD_POP_BACK, idxlst_pkg::MD_POP_FRONT: if (occ > 0) occ--;
      default: ;
    endcase
    if (occ > peak) peak = occ;
  endfunction

  // Drive one item at this edge, hold it until taken, then maybe pause
  task automatic send_item(input idxlst_pkg::mode_t m, input logic [5:0] p,
                           input logic [31:0] v, input bit may_idle);
    idxlst_pkg::request_t rq;
    int                   gap;
    rq.mode       = m;
    rq.position   = p;
    rq.item_value = v;
    request <= rq;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    note_accepted(m, p);
    sent++;
    if (may_idle && $urandom_range(99) < 9) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(70, 1) : $urandom_range(8, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every response owed has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic idxlst_pkg::mode_t pick_mode(input phase_t ph);
    int unsigned r;
    r = $urandom_range(99);
    if ((ph == PH_GROW && r < 70) || (ph == PH_BRIM && r < 75))
      return idxlst_pkg::mode_t'($urandom_range(int'(idxlst_pkg::MD_INSERT),
                                                int'(idxlst_pkg::MD_PUSH_BACK)));
    if (ph == PH_SHRINK && r < 65)
      return idxlst_pkg::mode_t'($urandom_range(int'(idxlst_pkg::MD_POP_FRONT),
                                                int'(idxlst_pkg::MD_ERASE)));
    return idxlst_pkg::mode_t'($urandom_range(int'(idxlst_pkg::MD_GET),
                                              int'(idxlst_pkg::MD_PUSH_BACK)));
  endfunction

  // Mostly valid positions, some at the boundary, some anywhere
  function automatic logic [5:0] pick_position(input idxlst_pkg::mode_t m);
    int unsigned r;
    int          hi;
    logic [5:0]  p;
    r  = $urandom_range(99);
    hi = (m == idxlst_pkg::MD_INSERT || occ == 0) ? occ : occ - 1;
    if (hi > 63) hi = 63;
    if (r < 15) p = 6'($urandom_range(63));
    else if (r < 22) p = (occ > 63) ? 6'd63 : 6'(occ);
    else p = 6'($urandom_range(hi));
    return p;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Stimulus
  initial begin
    phase_t            ph;
    int                stint;
    int                n;
    int                guard;
    int                directed;
    idxlst_pkg::mode_t m;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty list: every read-type request and a misplaced insert
    send_item(idxlst_pkg::MD_GET,        6'd0,  32'h1234_5678, 1'b1);
    send_item(idxlst_pkg::MD_POP_BACK,   6'd0,  '0,            1'b1);
    send_item(idxlst_pkg::MD_POP_FRONT,  6'd0,  '0,            1'b1);
    send_item(idxlst_pkg::MD_ERASE,      6'd0,  '0,            1'b1);
    send_item(idxlst_pkg::MD_UPDATE,     6'd5,  32'hdead_beef, 1'b1);
    send_item(idxlst_pkg::MD_INSERT,     6'd1,  32'h1111_1111, 1'b1);
    // build a short list from the word extremes
    send_item(idxlst_pkg::MD_PUSH_BACK,  6'd63, 32'h7fff_ffff, 1'b1);
    send_item(idxlst_pkg::MD_PUSH_FRONT, 6'd63, 32'h8000_0000, 1'b1);
    send_item(idxlst_pkg::MD_INSERT,     6'd2,  32'hffff_ffff, 1'b1);
    send_item(idxlst_pkg::MD_INSERT,     6'd1,  32'h0000_0000, 1'b1);
    // index past the end, update, read back, erase at and past the end
    send_item(idxlst_pkg::MD_GET,        6'd63, '0,            1'b1);
    send_item(idxlst_pkg::MD_UPDATE,     6'd1,  32'h5a5a_5a5a, 1'b1);
    send_item(idxlst_pkg::MD_GET,        6'd1,  '0,            1'b1);
    send_item(idxlst_pkg::MD_GET,        6'd3,  '0,            1'b1);
    send_item(idxlst_pkg::MD_ERASE,      6'd3,  '0,            1'b1);
    send_item(idxlst_pkg::MD_ERASE,      6'd3,  '0,            1'b1);
    send_item(idxlst_pkg::MD_UPDATE,     6'd3,  32'h0f0f_0f0f, 1'b1);
    send_item(idxlst_pkg::MD_POP_FRONT,  6'd0,  '0,            1'b1);
    send_item(idxlst_pkg::MD_GET,        6'd0,  '0,            1'b1);
    send_item(idxlst_pkg::MD_POP_BACK,   6'd0,  '0,            1'b1);
    send_item(idxlst_pkg::MD_GET,        6'd0,  '0,            1'b1);
    send_item(idxlst_pkg::MD_INSERT,     6'd0,  32'ha5a5_0f0f, 1'b1);
    send_item(idxlst_pkg::MD_GET,        6'd0,  '0,            1'b1);
    directed = sent;
    drain();

    // random phases cycling grow, fill to the brim, churn, shrink
    ph    = PH_GROW;
    stint = $urandom_range(180, 60);
    for (n = 0; n < 1500; n++) begin
      if (stint == 0) begin
        ph    = (ph == PH_SHRINK) ? PH_GROW : phase_t'(ph + 1);
        stint = $urandom_range(180, 60);
      end
      stint--;
      m = pick_mode(ph);
      send_item(m, pick_position(m), pick_value(), !(n >= 500 && n < 800));
      if (n == 300 || n == 1100) drain();
    end

    // wind down
    start <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (outstanding != 0 && guard < 5000);
    repeat (70) @(posedge clk);

    $display("%0d requests (%0d directed) over all modes; list peaked at %0d entries",
             sent, directed, peak);
    $display("%0d pushes or inserts refused on a full list", full_refused);
    if (faults == 0 && outstanding == 0) begin
      $display("indexed_list_insert_erase: match");
    end else begin
      if (outstanding != 0) $display("%0d responses never arrived", outstanding);
      $display("indexed_list_insert_erase: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("indexed_list_insert_erase: mismatch");
    $finish;
  end

endmodule
